[rtl/core/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent in this cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/gfc_pkg.sv]
// shared types, codes and reset values for the gated frequency counter
// no dependencies
package gfc_pkg;

    localparam int unsigned CfgAddrWidth = 3;
    localparam int unsigned CfgDataWidth = 16;

    localparam logic [CfgAddrWidth-1:0] REG_HOLD_TICKS   = 3'd0;
    localparam logic [CfgAddrWidth-1:0] REG_RETRY_TICKS  = 3'd1;
    localparam logic [CfgAddrWidth-1:0] REG_GOOD_VOLTAGE = 3'd2;
    localparam logic [CfgAddrWidth-1:0] REG_FREQ_LIMIT   = 3'd3;
    localparam logic [CfgAddrWidth-1:0] REG_FAULT_VALUE  = 3'd4;
    localparam logic [CfgAddrWidth-1:0] REG_BUSY_BYTE    = 3'd5;

    localparam logic [7:0]  HOLD_TICKS_RST   = 8'd50;
    localparam logic [7:0]  RETRY_TICKS_RST  = 8'd5;
    localparam logic [9:0]  GOOD_VOLTAGE_RST = 10'd100;
    localparam logic [15:0] FREQ_LIMIT_RST   = 16'h1770;
    localparam logic [15:0] FAULT_VALUE_RST  = 16'h0001;
    localparam logic [7:0]  BUSY_BYTE_RST    = 8'h12;

    typedef enum logic [1:0] {
        EV_TICK     = 2'd0,
        EV_EDGE     = 2'd1,
        EV_RST_REQ  = 2'd2,
        EV_SPI_DONE = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [7:0]  hold_ticks;
        logic [7:0]  retry_ticks;
        logic [9:0]  good_voltage;
        logic [15:0] freq_limit;
        logic [15:0] fault_value;
        logic [7:0]  busy_byte;
    } cfg_t;

    typedef struct packed {
        logic        holding;
        logic [15:0] frequency;
        logic        spi_loaded;
        logic [7:0]  spi_byte;
        logic        reset_drive;
    } result_t;

endpackage

[rtl/core/gfc_core.sv]
// state of the counter and reset guard, updated once per item
// depends on gfc_pkg
module gfc_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  gfc_pkg::event_kind_t kind,
    input  logic                pin_low,
    input  logic [9:0]          sample,
    input  gfc_pkg::cfg_t       cfg,
    output gfc_pkg::result_t    result
);
    import gfc_pkg::*;

    logic        hold_active_reg, hold_active_next;
    logic [7:0]  hold_count_reg, hold_count_next;
    logic [15:0] edge_count_reg, edge_count_next;
    logic [15:0] captured_reg, captured_next;
    logic        send_pending_reg, send_pending_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        reset_level_reg, reset_level_next;
    logic        loaded;
    logic [15:0] clamped;

    assign clamped = (edge_count_reg >= cfg.freq_limit) ? cfg.fault_value : edge_count_reg;

    always_comb
    begin
        hold_active_next  = hold_active_reg;
        hold_count_next   = hold_count_reg;
        edge_count_next   = edge_count_reg;
        captured_next     = captured_reg;
        send_pending_next = send_pending_reg;
        tx_byte_next      = tx_byte_reg;
        reset_level_next  = reset_level_reg;
        loaded            = 1'b0;
        unique case (kind)
            EV_TICK:
            begin
                if (hold_active_reg)
                begin
                    if (hold_count_reg == 8'd0)
                    begin
                        // countdown expired: release only on a good supply
                        if (sample > cfg.good_voltage)
                        begin
                            hold_count_next  = 8'd0;
                            hold_active_next = 1'b0;
                            reset_level_next = 1'b1;
                        end
                        else
                        begin
                            hold_count_next = cfg.retry_ticks;
                        end
                    end
                    else
                    begin
                        hold_count_next = hold_count_reg - 8'd1;
                    end
                    edge_count_next = 16'd0;
                    tx_byte_next    = cfg.busy_byte;
                    loaded          = 1'b1;
                end
                else if (send_pending_reg)
                begin
                    captured_next   = clamped;
                    tx_byte_next    = clamped[15:8];
                    edge_count_next = 16'd0;
                    loaded          = 1'b1;
                end
            end
            EV_EDGE:
            begin
                edge_count_next = edge_count_reg + 16'd1;
            end
            EV_RST_REQ:
            begin
                if (pin_low)
                begin
                    hold_active_next = 1'b1;
                    hold_count_next  = cfg.hold_ticks;
                    reset_level_next = 1'b0;
                end
            end
            EV_SPI_DONE:
            begin
                if (send_pending_reg)
                begin
                    tx_byte_next      = captured_reg[7:0];
                    send_pending_next = 1'b0;
                    loaded            = 1'b1;
                end
                else
                begin
                    send_pending_next = 1'b1;
                end
            end
            default:
            begin
                loaded = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_active_reg  <= 1'b0;
            hold_count_reg   <= 8'd0;
            edge_count_reg   <= 16'd0;
            captured_reg     <= 16'd0;
            send_pending_reg <= 1'b1;
            tx_byte_reg      <= 8'd0;
            reset_level_reg  <= 1'b1;
        end
        else if (step)
        begin
            hold_active_reg  <= hold_active_next;
            hold_count_reg   <= hold_count_next;
            edge_count_reg   <= edge_count_next;
            captured_reg     <= captured_next;
            send_pending_reg <= send_pending_next;
            tx_byte_reg      <= tx_byte_next;
            reset_level_reg  <= reset_level_next;
        end
    end

    assign result.reset_drive = reset_level_next;
    assign result.spi_byte    = tx_byte_next;
    assign result.spi_loaded  = loaded;
    assign result.frequency   = captured_next;
    assign result.holding     = hold_active_next;

endmodule

[rtl/core/gated_frequency_counter_reset_guard.sv]
// Gated frequency counter with reset guard. Takes one item per clock while the result side is not
// stalled; each item gives exactly one result: the input register takes the item, then the single
// state update stage runs and writes the result register, from which the result is presented.
// Back-pressure on the result side stalls both stages; the input side stays ready while the input
// register can move on. Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user
// must do so only while no item is in flight, the block itself does not enforce this.
// depends on gfc_pkg and gfc_core
module gated_frequency_counter_reset_guard
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // reset_pin_low, voltage_sample
    input  logic [1:0]                        s_axis_tuser,  // event_kind
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // reset_drive, spi_byte, spi_loaded, frequency, holding
    output logic [31:0]                       m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [gfc_pkg::CfgAddrWidth-1:0]  cfg_addr,
    input  logic [gfc_pkg::CfgDataWidth-1:0]  cfg_wdata
);
    import gfc_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [1:0]  in_kind_reg;
    logic        in_pin_reg;
    logic [9:0]  in_sample_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    result_t     result;
    logic        out_free;
    logic        advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ticks   <= HOLD_TICKS_RST;
            cfg_reg.retry_ticks  <= RETRY_TICKS_RST;
            cfg_reg.good_voltage <= GOOD_VOLTAGE_RST;
            cfg_reg.freq_limit   <= FREQ_LIMIT_RST;
            cfg_reg.fault_value  <= FAULT_VALUE_RST;
            cfg_reg.busy_byte    <= BUSY_BYTE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_HOLD_TICKS:   cfg_reg.hold_ticks   <= cfg_wdata[7:0];
                REG_RETRY_TICKS:  cfg_reg.retry_ticks  <= cfg_wdata[7:0];
                REG_GOOD_VOLTAGE: cfg_reg.good_voltage <= cfg_wdata[9:0];
                REG_FREQ_LIMIT:   cfg_reg.freq_limit   <= cfg_wdata;
                REG_FAULT_VALUE:  cfg_reg.fault_value  <= cfg_wdata;
                REG_BUSY_BYTE:    cfg_reg.busy_byte    <= cfg_wdata[7:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg   <= s_axis_tuser;
            in_pin_reg    <= s_axis_tdata[0];
            in_sample_reg <= s_axis_tdata[10:1];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    gfc_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .kind    (event_kind_t'(in_kind_reg)),
        .pin_low (in_pin_reg),
        .sample  (in_sample_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_data_reg.holding, out_data_reg.frequency,
                            out_data_reg.spi_loaded, out_data_reg.spi_byte,
                            out_data_reg.reset_drive};

endmodule

[rtl/core/gfc_checker.sv]
// port-level checks for the gated frequency counter, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module gfc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_stall_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                 m_axis_tvalid && $stable(m_axis_tdata))

    // reset is driven low exactly while a hold is active
    `ASSERT_ALWAYS(a_drive_vs_hold, clk, rst_n,
                   !m_axis_tvalid || (m_axis_tdata[0] != m_axis_tdata[26]))

    // input side only stalls when a result is blocked downstream
    `ASSERT_ALWAYS(a_ready_only_on_stall, clk, rst_n,
                   s_axis_tready || (m_axis_tvalid && !m_axis_tready))

    // the padding bits of the result stay zero
    `ASSERT_ALWAYS(a_out_pad_zero, clk, rst_n,
                   !m_axis_tvalid || (m_axis_tdata[31:27] == 5'd0))

endmodule

bind gated_frequency_counter_reset_guard gfc_checker u_gfc_checker (.*);
